// ===== rtl/chrl_pkg.sv =====
// shared types and constants for the consistent hash ring lookup block
package chrl_pkg;

  localparam int unsigned PointW       = 64;
  localparam int unsigned PartW        = 7;
  localparam int unsigned MaxPointsDef = 64;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_GEN    = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ZERO  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV,
    FSM_FILL,
    FSM_DONE
  } fsm_e;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic cap;    // register compare flags against the operand
    logic ins;    // commit an ordered insert
    logic shift;  // plain shift toward higher index
  } cell_ctl_t;

endpackage

// ===== rtl/chrl_if.sv =====
// request and response channel interfaces
interface chrl_req_if;
  logic                         valid;
  logic                         ready;
  chrl_pkg::req_e               req_type;
  logic [chrl_pkg::PointW-1:0]  key_hash;
  logic [chrl_pkg::PointW-1:0]  point_value;
  logic [chrl_pkg::PartW-1:0]   part_count;

  modport source (output valid, req_type, key_hash, point_value, part_count, input ready);
  modport sink   (input valid, req_type, key_hash, point_value, part_count, output ready);
endinterface

interface chrl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [chrl_pkg::PointW-1:0]  partition;
  chrl_pkg::status_e            status;

  modport source (output valid, partition, status, input ready);
  modport sink   (input valid, partition, status, output ready);
endinterface

// ===== rtl/chrl_cell.sv =====
// one ring slot: holds a point, compares it and hands it to the next slot
module chrl_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chrl_pkg::cell_ctl_t         ctl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [chrl_pkg::PointW-1:0] op_i,
  input  logic [chrl_pkg::PointW-1:0] new_pt_i,
  input  logic [chrl_pkg::PointW-1:0] prev_pt_i,
  input  logic                        prev_lt_i,
  output logic [chrl_pkg::PointW-1:0] pt_o,
  output logic                        lt_o,
  output logic                        eq_o,
  output logic                        hit_o,
  output logic [chrl_pkg::PointW-1:0] sel_o
);
  import chrl_pkg::*;

  logic [PointW-1:0] pt_q;
  logic              lt_q, ge_q, eq_q;
  logic              valid;

  assign valid = CNT_W'(IDX) < count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      ge_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cap) begin
      lt_q <= valid && (pt_q < op_i);
      ge_q <= valid && !(pt_q < op_i);
      eq_q <= valid && (pt_q == op_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      pt_q <= prev_pt_i;
    end else if (ctl_i.ins && !lt_q) begin
      pt_q <= prev_lt_i ? new_pt_i : prev_pt_i;
    end
  end

  assign pt_o  = pt_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;
  assign hit_o = ge_q && prev_lt_i;
  assign sel_o = hit_o ? pt_q : '0;

endmodule

// ===== rtl/chrl_div.sv =====
// restoring divider of the all-ones word by a small count, one bit per cycle
module chrl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chrl_pkg::PartW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [chrl_pkg::PointW-1:0] quo_o,
  output logic [chrl_pkg::PartW-1:0]  rem_o
);
  import chrl_pkg::*;

  localparam int unsigned StepW = $clog2(PointW);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [PointW-1:0] quo_q;
  logic [PartW-1:0]  rem_q, rem_d;
  logic [PartW:0]    trial, diff;
  logic              fits;

  // each step brings down a one bit of the dividend
  assign trial = {rem_q, 1'b1};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign rem_d = fits ? diff[PartW-1:0] : trial[PartW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(PointW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[PointW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/consistent_hash_ring_lookup_top.sv =====
// top level of the consistent hash ring lookup block
// The ring table is a chain of MAX_POINTS cells kept in ascending order with no duplicates.
// Every request gives one response transaction. For clear, insert and lookup the cells
// register their compares against the operand at the accepting edge, and once the response
// register is free the exec state commits the ordered insert (each cell loads from its lower
// neighbor) or selects the first point at or above the hash, wrapping to the smallest point.
// Generate runs through its states in order: exec decodes the request, div runs a
// bit-serial divider that forms floor((2^64-1)/N), the largest point is formed as the
// divider reports done, fill shifts the points into the chain from cell 0 (largest
// first, one per cycle), and done loads the response before the return to idle.
// One request is in work at a time; the response register lets the next request be
// accepted while the previous response still waits to be taken.
module consistent_hash_ring_lookup_top #(
  parameter int unsigned MAX_POINTS = chrl_pkg::MaxPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chrl_req_if.sink    req_i,
  chrl_rsp_if.source  rsp_o
);
  import chrl_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  fsm_e              state_q, state_d;
  req_e              req_q;
  logic [PointW-1:0] pv_q;
  logic [PartW-1:0]  n_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PointW-1:0] acc_q;
  logic [PartW-1:0]  fill_q;

  logic              out_valid_q;
  logic [PointW-1:0] part_q;
  status_e           status_q;

  // cell chain wiring
  logic [PointW-1:0] pt_w   [MAX_POINTS];
  logic [PointW-1:0] sel_w  [MAX_POINTS];
  logic [MAX_POINTS-1:0] lt_w, eq_w, hit_w;
  cell_ctl_t         ctl;

  logic              accept, out_free, gen_ok, dup, any_hit, is_full;
  logic [PointW-1:0] hit_val;
  logic [PointW-1:0] op;
  logic              out_load, ins_commit, div_start, div_done;
  logic [PointW-1:0] out_part;
  status_e           out_status;
  logic [PointW-1:0] quo;
  logic [PartW-1:0]  rem;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == FSM_IDLE);

  // compares run against the hash for a lookup and against the new point otherwise
  assign op = (req_i.req_type == REQ_LOOKUP) ? req_i.key_hash : req_i.point_value;

  assign gen_ok  = (n_q != '0) && (int'(n_q) <= MAX_POINTS);
  assign is_full = cnt_q >= CntW'(MAX_POINTS);

  // or-reduce the per-cell flags; sorting makes at most one cell hit
  always_comb begin
    dup     = 1'b0;
    any_hit = 1'b0;
    hit_val = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      dup     = dup | eq_w[i];
      any_hit = any_hit | hit_w[i];
      hit_val = hit_val | sel_w[i];
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [PointW-1:0] prev_pt;
    logic              prev_lt;
    if (i == 0) begin : g_head
      assign prev_pt = acc_q;
      assign prev_lt = 1'b1;
    end else begin : g_body
      assign prev_pt = pt_w[i-1];
      assign prev_lt = lt_w[i-1];
    end
    chrl_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .count_i   (cnt_q),
      .op_i      (op),
      .new_pt_i  (pv_q),
      .prev_pt_i (prev_pt),
      .prev_lt_i (prev_lt),
      .pt_o      (pt_w[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i]),
      .hit_o     (hit_w[i]),
      .sel_o     (sel_w[i])
    );
  end

  chrl_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (req_q == REQ_GEN && gen_ok) state_d = FSM_DIV;
        else if (out_free)              state_d = FSM_IDLE;
      end
      FSM_DIV: begin
        if (div_done) state_d = FSM_FILL;
      end
      FSM_FILL: begin
        if (fill_q == PartW'(1)) state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath controls and response
  always_comb begin
    ctl        = '0;
    ctl.cap    = accept;
    out_load   = 1'b0;
    out_part   = '0;
    out_status = ST_OK;
    ins_commit = 1'b0;
    div_start  = 1'b0;
    cnt_d      = cnt_q;
    unique case (state_q)
      FSM_EXEC: begin
        if (req_q == REQ_GEN && gen_ok) begin
          div_start = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          case (req_q)
            REQ_CLEAR: cnt_d = '0;
            REQ_INSERT: begin
              if (!dup) begin
                if (is_full) begin
                  out_status = ST_FULL;
                end else begin
                  ins_commit = 1'b1;
                  cnt_d      = cnt_q + CntW'(1);
                end
              end
            end
            REQ_GEN: out_status = (n_q == '0) ? ST_ZERO : ST_FULL;
            default: begin
              if (cnt_q == '0) begin
                out_status = ST_EMPTY;
              end else begin
                out_part = any_hit ? hit_val : pt_w[0];
              end
            end
          endcase
        end
      end
      FSM_FILL: ctl.shift = 1'b1;
      FSM_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          cnt_d    = CntW'(n_q);
        end
      end
      default: ;
    endcase
    ctl.ins = ins_commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.req_type;
      pv_q  <= req_i.point_value;
      n_q   <= req_i.part_count;
    end
    if (out_load) begin
      part_q   <= out_part;
      status_q <= out_status;
    end
    // largest point first: (n-1)*q = (2^64-1) - r - q, then step down by q
    if (div_done) begin
      acc_q  <= '1 - PointW'(rem) - quo;
      fill_q <= n_q;
    end else if (state_q == FSM_FILL) begin
      acc_q  <= acc_q - quo;
      fill_q <= fill_q - PartW'(1);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.partition = part_q;
  assign rsp_o.status    = status_q;

  // table never grows past capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_POINTS))
    else $error("point count above capacity");

  // an accepted transaction is worked in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == FSM_EXEC)
    else $error("accepted transaction not executed");

  // an insert commit adds exactly one point
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_commit |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("insert did not add one point");

  // the divider only finishes while the sequencer waits for it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == FSM_DIV)
    else $error("divider finished outside generate");

  // a response is never loaded over one that has not been taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("response overwritten");

endmodule
